// ===== rtl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// shared types and constants of the distance constraint solver
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int MASS_W     = 16;  // unsigned Q8.8 mass
  localparam int ELONG_W    = 16;  // unsigned Q8.8 break factor
  localparam int ELONG_FRAC = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELONG    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TENSION_ONLY = CFG_IDX_W'(1);

  // lane order of the four moves
  localparam int LANE_X1 = 0;
  localparam int LANE_Y1 = 1;
  localparam int LANE_X2 = 2;
  localparam int LANE_Y2 = 3;
  localparam int LANES   = 4;

  // per-item control carried alongside the divider
  typedef struct packed {
    logic             snapped;
    logic             applied;
    logic [LANES-1:0] neg;
  } res_ctrl_t;

endpackage

// ===== rtl/dcs_sqrt.sv =====
// ----------------------------------------------------------------------------
// dcs_sqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module dcs_sqrt #(
  parameter int RAD_W  = 65,
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int TW = 2 * ROOT_W + 1;

  logic              vld_q  [ROOT_W];
  logic [TW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic              vld_in;
    logic [TW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     trial;
    logic              fit;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = TW'(rad_i);
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (r + 2^b)^2 - r^2, bits of r all above b
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign fit   = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= fit ? rem_in - trial : rem_in;
      root_q[s] <= fit ? (root_in | (ROOT_W'(1) << B)) : root_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// ===== rtl/dcs_div.sv =====
// ----------------------------------------------------------------------------
// dcs_div
// pipelined restoring divider, several numerators over one denominator
// ----------------------------------------------------------------------------
module dcs_div
  import dcs_pkg::*;
#(
  parameter int NUM_W = 81,
  parameter int DEN_W = 52,
  parameter int QUO_W = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [LANES-1:0][NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  res_ctrl_t                   ctrl_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QUO_W-1:0] quo_o,
  output res_ctrl_t                   ctrl_o
);

  // quotient is known to stay below 2^QUO_W
  localparam int RW = DEN_W + QUO_W;

  logic                        vld_q  [QUO_W];
  logic [LANES-1:0][RW-1:0]    rem_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_q  [QUO_W];
  logic [DEN_W-1:0]            den_q  [QUO_W];
  res_ctrl_t                   ctrl_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic                        vld_in;
    logic [LANES-1:0][RW-1:0]    rem_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [DEN_W-1:0]            den_in;
    res_ctrl_t                   ctrl_in;
    logic [RW-1:0]               trial;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign ctrl_in = ctrl_i;
      assign quo_in  = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = RW'(num_i[l]);
      end
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign ctrl_in = ctrl_q[s-1];
    end

    assign trial = RW'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= trial) begin
          rem_q[s][l] <= rem_in[l] - trial;
          quo_q[s][l] <= {quo_in[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_q[s][l] <= rem_in[l];
          quo_q[s][l] <= {quo_in[l][QUO_W-2:0], 1'b0};
        end
      end
      den_q[s]  <= den_in;
      ctrl_q[s] <= ctrl_in;
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign ctrl_o  = ctrl_q[QUO_W-1];

endmodule

// ===== rtl/distance_constraint_solve_core.sv =====
// ----------------------------------------------------------------------------
// distance_constraint_solve_core
// 2-D distance constraint between two bodies, fully pipelined
// ----------------------------------------------------------------------------
// One constraint enters per clock and busy_o is never raised. Each result
// appears on the move ports for exactly one cycle with result_valid_o;
// the receiver cannot stall, so nothing is held back. The pipeline is made
// of the square root (one root bit per stage, COORD_BITS+1 stages) and the
// divider that forms the four moves (one quotient bit per stage, COORD_BITS
// stages), plus eight stages of difference, square, sum, limit, break test,
// product and output logic.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module distance_constraint_solve_core
  import dcs_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item transfer
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COORD_BITS-1:0] pos_x1_i,
  input  logic [COORD_BITS-1:0] pos_y1_i,
  input  logic [COORD_BITS-1:0] pos_x2_i,
  input  logic [COORD_BITS-1:0] pos_y2_i,
  input  logic [MASS_W-1:0]     mass_a_i,
  input  logic [MASS_W-1:0]     mass_b_i,
  input  logic [COORD_BITS-2:0] rest_length_i,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // results
  output logic                  result_valid_o,
  output logic [COORD_BITS-1:0] move_x1_o,
  output logic [COORD_BITS-1:0] move_y1_o,
  output logic [COORD_BITS-1:0] move_x2_o,
  output logic [COORD_BITS-1:0] move_y2_o,
  output logic                  snapped_o,
  output logic                  applied_o
);

  localparam int CW     = COORD_BITS;
  localparam int SQ_W   = 2 * CW + 1;          // sum of squares
  localparam int DIST_W = CW + 1;              // root of the sum
  localparam int REST_W = CW - 1;
  localparam int WD_W   = MASS_W + 1;          // mass_a + mass_b
  localparam int PROD_W = CW + DIST_W;         // component times length error
  localparam int NUM_W  = PROD_W + MASS_W;
  localparam int DEN_W  = DIST_W + 1 + WD_W;   // 2 * dist * weight sum
  localparam int QUO_W  = CW;
  localparam int LIM_W  = REST_W + ELONG_W;
  localparam int CMP_W  = DIST_W + ELONG_W + 1;

  typedef struct packed {
    logic [CW-1:0]     mx;
    logic              nx;
    logic [CW-1:0]     my;
    logic              ny;
    logic [MASS_W-1:0] ma;
    logic [MASS_W-1:0] mb;
    logic [REST_W-1:0] rest;
  } geom_t;

  // never stalls
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ELONG_W-1:0] max_elong_q;
  logic               tension_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_elong_q    <= '0;
      tension_only_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_ELONG:    max_elong_q    <= cfg_data_i[ELONG_W-1:0];
        REG_TENSION_ONLY: tension_only_q <= cfg_data_i[0];
        default:          ;  // writes beyond the list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: joining vector as sign and magnitude
  // --------------------------------------------------------------------------
  logic          s1_vld_q;
  geom_t         s1_q, s1_d;
  logic [CW-1:0] ux1, ux2, uy1, uy2;

  always_comb begin
    // offset binary makes the signed compare unsigned
    ux1 = {~pos_x1_i[CW-1], pos_x1_i[CW-2:0]};
    ux2 = {~pos_x2_i[CW-1], pos_x2_i[CW-2:0]};
    uy1 = {~pos_y1_i[CW-1], pos_y1_i[CW-2:0]};
    uy2 = {~pos_y2_i[CW-1], pos_y2_i[CW-2:0]};
    s1_d.nx   = ux1 < ux2;
    s1_d.mx   = s1_d.nx ? ux2 - ux1 : ux1 - ux2;
    s1_d.ny   = uy1 < uy2;
    s1_d.my   = s1_d.ny ? uy2 - uy1 : uy1 - uy2;
    s1_d.ma   = mass_a_i;
    s1_d.mb   = mass_b_i;
    s1_d.rest = rest_length_i;
  end

  // --------------------------------------------------------------------------
  // stages 2 and 3: squares, then their sum
  // --------------------------------------------------------------------------
  logic            s2_vld_q, s3_vld_q;
  geom_t           s2_q, s3_q;
  logic [2*CW-1:0] sqx_q, sqy_q;
  logic [SQ_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    sqx_q <= (2*CW)'(s1_q.mx) * (2*CW)'(s1_q.mx);
    sqy_q <= (2*CW)'(s1_q.my) * (2*CW)'(s1_q.my);
    s2_q  <= s1_q;
    sum_q <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
    s3_q  <= s2_q;
  end

  // --------------------------------------------------------------------------
  // square root
  // --------------------------------------------------------------------------
  logic              rt_vld;
  logic [DIST_W-1:0] rt_dist;
  geom_t             rt_geom;

  dcs_sqrt #(
    .RAD_W  (SQ_W),
    .ROOT_W (DIST_W),
    .SIDE_W ($bits(geom_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .rad_i   (sum_q),
    .side_i  (s3_q),
    .valid_o (rt_vld),
    .root_o  (rt_dist),
    .side_o  (rt_geom)
  );

  // --------------------------------------------------------------------------
  // stage 4: break limit rest * factor
  // --------------------------------------------------------------------------
  logic              s4_vld_q;
  geom_t             s4_q;
  logic [DIST_W-1:0] s4_dist_q;
  logic [LIM_W-1:0]  s4_lim_q;

  always_ff @(posedge clk_i) begin
    s4_q      <= rt_geom;
    s4_dist_q <= rt_dist;
    s4_lim_q  <= LIM_W'(rt_geom.rest) * LIM_W'(max_elong_q);
  end

  // --------------------------------------------------------------------------
  // stage 5: break test, special cases, weights and signs
  // --------------------------------------------------------------------------
  logic              s5_vld_q;
  res_ctrl_t         s5_ctrl_q, s5_ctrl_d;
  logic [CW-1:0]     s5_mx_q, s5_my_q;
  logic [DIST_W-1:0] s5_dist_q, s5_dmag_q, s5_dmag_d;
  logic [MASS_W-1:0] s5_w1_q, s5_w2_q, s5_w1_d, s5_w2_d;
  logic [WD_W-1:0]   s5_wd_q, s5_wd_d;
  logic [DIST_W-1:0] rest_ext;
  logic              brk, dneg, skip;

  always_comb begin
    rest_ext = DIST_W'(s4_q.rest);
    brk  = (max_elong_q != '0) &&
           ((CMP_W'(s4_dist_q) << ELONG_FRAC) > CMP_W'(s4_lim_q));
    dneg = s4_dist_q < rest_ext;
    s5_dmag_d = dneg ? rest_ext - s4_dist_q : s4_dist_q - rest_ext;
    // broken link, coincident bodies, exact length or slack link under tension-only
    skip = brk || (s4_dist_q == '0) || (s4_dist_q == rest_ext) ||
           (tension_only_q && dneg);
    s5_ctrl_d.snapped       = brk;
    s5_ctrl_d.applied       = !skip;
    s5_ctrl_d.neg[LANE_X2]  = s4_q.nx != dneg;
    s5_ctrl_d.neg[LANE_Y2]  = s4_q.ny != dneg;
    s5_ctrl_d.neg[LANE_X1]  = s4_q.nx == dneg;
    s5_ctrl_d.neg[LANE_Y1]  = s4_q.ny == dneg;
    // mass weighting only for a stretched link with both masses set
    if ((s4_q.ma != '0) && (s4_q.mb != '0) && !dneg) begin
      s5_w1_d = s4_q.mb;
      s5_w2_d = s4_q.ma;
      s5_wd_d = WD_W'(s4_q.ma) + WD_W'(s4_q.mb);
    end else begin
      s5_w1_d = MASS_W'(1);
      s5_w2_d = MASS_W'(1);
      s5_wd_d = WD_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    s5_ctrl_q <= s5_ctrl_d;
    s5_mx_q   <= s4_q.mx;
    s5_my_q   <= s4_q.my;
    s5_dist_q <= s4_dist_q;
    s5_dmag_q <= s5_dmag_d;
    s5_w1_q   <= s5_w1_d;
    s5_w2_q   <= s5_w2_d;
    s5_wd_q   <= s5_wd_d;
  end

  // --------------------------------------------------------------------------
  // stages 6 and 7: numerators and common denominator
  // --------------------------------------------------------------------------
  logic                        s6_vld_q, s7_vld_q;
  res_ctrl_t                   s6_ctrl_q, s7_ctrl_q;
  logic [PROD_W-1:0]           s6_px_q, s6_py_q;
  logic [MASS_W-1:0]           s6_w1_q, s6_w2_q;
  logic [DEN_W-1:0]            s6_den_q, s7_den_q;
  logic [LANES-1:0][NUM_W-1:0] s7_num_q;

  always_ff @(posedge clk_i) begin
    s6_ctrl_q <= s5_ctrl_q;
    s6_px_q   <= PROD_W'(s5_mx_q) * PROD_W'(s5_dmag_q);
    s6_py_q   <= PROD_W'(s5_my_q) * PROD_W'(s5_dmag_q);
    s6_den_q  <= (DEN_W'(s5_dist_q) << 1) * DEN_W'(s5_wd_q);
    s6_w1_q   <= s5_w1_q;
    s6_w2_q   <= s5_w2_q;

    s7_ctrl_q          <= s6_ctrl_q;
    s7_den_q           <= s6_den_q;
    s7_num_q[LANE_X1]  <= NUM_W'(s6_px_q) * NUM_W'(s6_w1_q);
    s7_num_q[LANE_Y1]  <= NUM_W'(s6_py_q) * NUM_W'(s6_w1_q);
    s7_num_q[LANE_X2]  <= NUM_W'(s6_px_q) * NUM_W'(s6_w2_q);
    s7_num_q[LANE_Y2]  <= NUM_W'(s6_py_q) * NUM_W'(s6_w2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= rt_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // divider: quotient is bounded by half the length error
  // --------------------------------------------------------------------------
  logic                        dv_vld;
  logic [LANES-1:0][QUO_W-1:0] dv_quo;
  res_ctrl_t                   dv_ctrl;

  dcs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_vld_q),
    .num_i   (s7_num_q),
    .den_i   (s7_den_q),
    .ctrl_i  (s7_ctrl_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .ctrl_o  (dv_ctrl)
  );

  // --------------------------------------------------------------------------
  // output stage: sign, saturation, zeroing of skipped items
  // --------------------------------------------------------------------------
  logic [LANES-1:0][CW-1:0] mv_d, mv_q;
  logic                     out_vld_q, snapped_q, applied_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [CW-1:0] lim;
      logic [CW-1:0] mag;
      lim = dv_ctrl.neg[l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      mag = (dv_quo[l] > lim) ? lim : dv_quo[l];
      if (!dv_ctrl.applied) begin
        mv_d[l] = '0;
      end else begin
        mv_d[l] = dv_ctrl.neg[l] ? (~mag + CW'(1)) : mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q      <= mv_d;
    snapped_q <= dv_ctrl.snapped;
    applied_q <= dv_ctrl.applied;
  end

  assign result_valid_o = out_vld_q;
  assign move_x1_o      = mv_q[LANE_X1];
  assign move_y1_o      = mv_q[LANE_Y1];
  assign move_x2_o      = mv_q[LANE_X2];
  assign move_y2_o      = mv_q[LANE_Y2];
  assign snapped_o      = snapped_q;
  assign applied_o      = applied_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_snap_not_applied : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(snapped_o && applied_o))
    else $error("broken link reported as applied");

  a_skipped_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !applied_o) |->
      (move_x1_o == '0 && move_y1_o == '0 && move_x2_o == '0 && move_y2_o == '0))
    else $error("nonzero move on a skipped item");

  a_entry_tracked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> s1_vld_q)
    else $error("accepted item lost at pipeline entry");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 2-d distance constraint solver
// ----------------------------------------------------------------------------
// A driver feeds constraints from a pending queue and a monitor compares every
// result with a software copy of the solver, phase by phase over several
// break-limit and tension-only settings and several sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
  import dcs_pkg::*;

  localparam int COORD_W = 32;
  localparam int SETTLE_CYCLES = 100;   // pipeline depth is 73 at 32 bits
  localparam int QUIET_LIMIT = 4000;    // cycles with no transfer at all
  localparam int HOLD_PCT = 100;        // idle rate that keeps the driver quiet
  // index past the end of the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

  typedef struct {
    logic signed [COORD_W-1:0] x1, y1, x2, y2;
    logic [MASS_W-1:0]         ma, mb;
    logic [COORD_W-2:0]        rest;
  } link_t;

  typedef struct {
    logic [COORD_W-1:0] mx1, my1, mx2, my2;
    logic               snapped, applied;
  } moves_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [COORD_W-1:0] move_x1_o, move_y1_o, move_x2_o, move_y2_o;
  logic snapped_o, applied_o;
  link_t cur_link = '{default: '0};

  // solver settings as the bench believes them to be
  logic [ELONG_W-1:0] elong_lim = '0;
  logic               tension_mode = 1'b0;

  link_t  pending_links[$];
  moves_t expected_moves[$];
  int     idle_pct = HOLD_PCT;
  int     errors = 0;
  int     quiet_cycles = 0;

  distance_constraint_solve_core #(.COORD_BITS(COORD_W)) uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .pos_x1_i(cur_link.x1), .pos_y1_i(cur_link.y1),
    .pos_x2_i(cur_link.x2), .pos_y2_i(cur_link.y2),
    .mass_a_i(cur_link.ma), .mass_b_i(cur_link.mb),
    .rest_length_i(cur_link.rest),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .move_x1_o, .move_y1_o, .move_x2_o, .move_y2_o,
    .snapped_o, .applied_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // magnitude and sign of a - b, exact in 33 bits
  function automatic logic [127:0] axis_gap(logic signed [COORD_W-1:0] a,
                                            logic signed [COORD_W-1:0] b,
                                            output bit neg);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    neg = d[COORD_W];
    m = neg ? -d : d;
    return 128'(m);
  endfunction

  // floor of the euclidean distance between the bodies
  function automatic logic [127:0] link_length(link_t l);
    logic [127:0] gx, gy, sq, r, c;
    bit nx, ny;
    gx = axis_gap(l.x1, l.x2, nx);
    gy = axis_gap(l.y1, l.y2, ny);
    sq = gx * gx + gy * gy;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= sq) r = c;
    end
    return r;
  endfunction

  // gap * stretch * wnum / (2 * span * wden), truncated toward zero, saturated
  function automatic logic [COORD_W-1:0] scaled_move(logic [127:0] gap, bit neg,
      logic [127:0] stretch, logic [127:0] wnum, logic [127:0] wden,
      logic [127:0] span);
    logic [127:0] q, lim;
    q = (gap * stretch * wnum) / (2 * span * wden);
    lim = (128'd1 << (COORD_W - 1)) - (neg ? 0 : 1);
    if (q > lim) q = lim;
    return neg ? -q[COORD_W-1:0] : q[COORD_W-1:0];
  endfunction

  function automatic moves_t solve_constraint(link_t l);
    logic [127:0] gx, gy, span, rest, stretch, w1, w2, wd;
    bit nx, ny, squeezed;
    moves_t r;
    r = '{default: '0};
    gx = axis_gap(l.x1, l.x2, nx);
    gy = axis_gap(l.y1, l.y2, ny);
    span = link_length(l);
    rest = 128'(l.rest);
    // break check against rest times the Q8.8 factor
    if (elong_lim != 0 && (span << ELONG_FRAC) > rest * elong_lim) begin
      r.snapped = 1'b1;
      return r;
    end
    if (span == 0 || span == rest) return r;
    squeezed = span < rest;
    stretch = squeezed ? rest - span : span - rest;
    if (tension_mode && squeezed) return r;
    w1 = 1;
    w2 = 1;
    wd = 1;
    // mass weighting only when stretched and both bodies have mass
    if (l.ma != 0 && l.mb != 0 && !squeezed) begin
      w1 = 128'(l.mb);
      w2 = 128'(l.ma);
      wd = 128'(l.ma) + 128'(l.mb);
    end
    r.mx2 = scaled_move(gx, nx != squeezed, stretch, w2, wd, span);
    r.my2 = scaled_move(gy, ny != squeezed, stretch, w2, wd, span);
    r.mx1 = scaled_move(gx, nx == squeezed, stretch, w1, wd, span);
    r.my1 = scaled_move(gy, ny == squeezed, stretch, w1, wd, span);
    r.applied = 1'b1;
    return r;
  endfunction

  // ------------------------------------------------------------ driver/monitor

  // driver: predict on each transfer, then offer the next pending link
  always @(posedge clk_i) begin : drive
    bit send;
    if (start_i && !busy_o) expected_moves.push_back(solve_constraint(cur_link));
    if (!start_i || !busy_o) begin
      send = rst_ni && pending_links.size() > 0 && $urandom_range(0, 99) >= idle_pct;
      if (send) begin
        cur_link <= pending_links.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [COORD_W-1:0] exp_v,
                                      logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // monitor: every strobe must match the oldest prediction
  always @(posedge clk_i) begin : observe
    moves_t e;
    if (result_valid_o) begin
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h %h %h %b %b",
                 $time, move_x1_o, move_y1_o, move_x2_o, move_y2_o, snapped_o, applied_o);
        errors++;
      end else begin
        e = expected_moves.pop_front();
        check_field("move_x1", e.mx1, move_x1_o);
        check_field("move_y1", e.my1, move_y1_o);
        check_field("move_x2", e.mx2, move_x2_o);
        check_field("move_y2", e.my2, move_y2_o);
        check_field("snapped", COORD_W'(e.snapped), COORD_W'(snapped_o));
        check_field("applied", COORD_W'(e.applied), COORD_W'(applied_o));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MAX_ELONG:    elong_lim = data;
      REG_TENSION_ONLY: tension_mode = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic link_t mk_link(int x1, int y1, int x2, int y2,
                                    int ma, int mb, int rest);
    link_t l;
    l.x1 = x1;
    l.y1 = y1;
    l.x2 = x2;
    l.y2 = y2;
    l.ma = MASS_W'(ma);
    l.mb = MASS_W'(mb);
    l.rest = (COORD_W-1)'(rest);
    return l;
  endfunction

  function automatic logic [MASS_W-1:0] rand_mass();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return '0;
    if (sel == 2) return '1;
    return MASS_W'($urandom);
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 1 << 23)) - (1 << 22);
  endfunction

  // mostly links near their rest length, some full range and coincident
  function automatic link_t random_link();
    link_t l;
    logic signed [127:0] r;
    int mode;
    mode = $urandom_range(0, 9);
    l.ma = rand_mass();
    l.mb = rand_mass();
    if (mode < 2) begin
      l = mk_link($urandom, $urandom, $urandom, $urandom, l.ma, l.mb, $urandom);
    end else if (mode == 2) begin
      l = mk_link($urandom, $urandom, 0, 0, l.ma, l.mb, $urandom);
      l.x2 = l.x1;
      l.y2 = l.y1;
    end else begin
      l = mk_link(near_coord(), near_coord(), near_coord(), near_coord(),
                  l.ma, l.mb, 0);
      r = link_length(l);
      case ($urandom_range(0, 3))
        0: ;
        1: r = r + $urandom_range(0, 16) - 8;
        2: r = (r * $urandom_range(0, 512)) >>> 8;
        default: r = $urandom;
      endcase
      if (r < 0) r = 0;
      l.rest = r[COORD_W-2:0];
    end
    return l;
  endfunction

  // the driver is held quiet outside a phase so that register writes never
  // overlap items in flight; links queued ahead wait for the new settings
  task automatic run_phase(int idle, logic [15:0] elong, logic tension, int count);
    write_reg(REG_MAX_ELONG, elong);
    write_reg(REG_TENSION_ONLY, 16'(tension));
    idle_pct = idle;
    repeat (count) pending_links.push_back(random_link());
    // drain, then let the pipeline settle before the next register write
    do @(negedge clk_i);
    while (pending_links.size() != 0 || start_i || expected_moves.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    idle_pct = HOLD_PCT;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, coincident bodies, exact rest, tiny and weighted moves
    write_reg(REG_SPARE, 16'hFFFF);
    pending_links.push_back(mk_link(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 0, 0, 0));
    pending_links.push_back(mk_link(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h8000_0000, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
    pending_links.push_back(mk_link(32'h1234_5678, -5, 32'h1234_5678, -5, 3, 4, 99));
    pending_links.push_back(mk_link(3 << 16, 4 << 16, 0, 0, 1, 1, 5 << 16));
    pending_links.push_back(mk_link(0, 0, -(3 << 16), -(4 << 16), 1, 1, 5 << 16));
    pending_links.push_back(mk_link(1, 1 << 30, 0, 0, 0, 0, (1 << 30) - 1));
    pending_links.push_back(mk_link(7, 9, 5, 6, 16'h0100, 16'h0300, 32'h7FFF_FFFF));
    pending_links.push_back(mk_link(10 << 16, 0, 0, 0, 0, 16'h0100, 2 << 16));
    pending_links.push_back(mk_link(0, 10 << 16, 0, 0, 16'hFFFF, 1, 2 << 16));
    pending_links.push_back(mk_link(-(1 << 20), 3 << 16, 1 << 20, -(3 << 16),
                                    16'h0200, 16'h0100, 1 << 16));
    pending_links.push_back(mk_link(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0,
                                    32'h7FFF_FFFF));
    run_phase(0, 16'h0000, 1'b0, 290);

    // break limit 1.5: over the limit, exactly on it, and zero rest
    pending_links.push_back(mk_link(10 << 16, 0, 0, 0, 0, 0, 1 << 16));
    pending_links.push_back(mk_link(3 << 16, 0, 0, 0, 0, 0, 2 << 16));
    pending_links.push_back(mk_link(0, 1, 0, 0, 5, 5, 0));
    pending_links.push_back(mk_link(4, 4, 4, 4, 5, 5, 0));
    run_phase(37, 16'h0180, 1'b0, 300);

    run_phase(75, 16'hFFFF, 1'b1, 300);
    run_phase(0, 16'h0100, 1'b1, 300);
    run_phase(37, 16'($urandom_range(256, 1024)), 1'($urandom), 200);
    run_phase(75, 16'($urandom), 1'b0, 200);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
